// File: rtl/core/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_OUT_W = 4;
  localparam int CMD_W       = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

  localparam logic signed [VAL_W-1:0] EMPTY_MARK = '1;

  // Per-cycle request broadcast to every cell.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [VAL_W-1:0] value;
  } spq_ctl_t;

endpackage

// File: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_command selects
//   push (insert in_value in descending order, ahead of equal values), pop
//   (remove the largest entry) or status. Push on a full queue and pop on an
//   empty queue leave the queue unchanged and report out_accepted = 0.
//   Result channel (out_valid/out_ready) returns exactly one status result per
//   request: largest and smallest entries (-1 when empty), count, empty and
//   full flags, and whether the request changed the queue.
// Timing:
//   All cells compare against the new value and shift at the edge that
//   accepts a request, so the queue is updated at that same edge. Its result
//   is loaded into the output register, raising out_valid, once the output
//   slot is free. Requests are taken one per cycle while the receiver keeps
//   out_ready high.
// Reset and stall:
//   rst_n (synchronous, active low) empties the queue and drops any pending
//   result. While the receiver stalls, the result register holds; one more
//   request is taken and parked, then in_ready falls until the result leaves.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CMD_W-1:0]              in_command,
  input  logic signed [VAL_W-1:0]       in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic signed [VAL_W-1:0]       out_highest,
  output logic signed [VAL_W-1:0]       out_lowest,
  output logic [COUNT_OUT_W-1:0]        out_count,
  output logic                          out_empty_res,
  output logic                          out_full_res
);

  // Queue state: cell chain holds entries, count and tail value live here.
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] lowest_r, lowest_nxt;
  logic                    full, empty;

  // Pending result: request applied, result not yet in output register.
  logic                    pending_r;
  logic                    acc_r;

  // Output register.
  logic                    out_valid_r;
  logic                    out_accepted_r;
  logic signed [VAL_W-1:0] out_highest_r;
  logic signed [VAL_W-1:0] out_lowest_r;
  logic [COUNT_OUT_W-1:0]  out_count_r;
  logic                    out_empty_r;
  logic                    out_full_r;

  logic                    in_fire;
  logic                    load_out;
  logic                    do_push, do_pop;
  spq_ctl_t                ctl;

  logic                    gt   [QUEUE_DEPTH];
  logic signed [VAL_W-1:0] cval [QUEUE_DEPTH];

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Load the result of the parked request whenever the output slot frees.
  assign load_out = pending_r && (!out_valid_r || out_ready);
  // Take a new request when nothing is parked or the parked one moves out now.
  assign in_ready = !pending_r || load_out;
  assign in_fire  = in_valid && in_ready;

  // Drop push when full and pop when empty; any other code is status only.
  assign do_push = in_fire && (in_command == CMD_PUSH) && !full;
  assign do_pop  = in_fire && (in_command == CMD_POP) && !empty;

  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;
  assign ctl.value = in_value;

  // Cell chain: slot 0 holds the largest entry.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                    occ;
    logic                    lgt;
    logic signed [VAL_W-1:0] lval;
    logic signed [VAL_W-1:0] rval;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign lgt  = 1'b1;
      assign lval = in_value;
    end else begin : g_body
      assign lgt  = gt[i-1];
      assign lval = cval[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rval = cval[i];
    end else begin : g_mid
      assign rval = cval[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_gt   (lgt),
      .left_val  (lval),
      .right_val (rval),
      .gt        (gt[i]),
      .val       (cval[i])
    );
  end

  // Track count and smallest entry alongside the chain.
  always_comb begin
    count_nxt  = count_r;
    lowest_nxt = lowest_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
      if (empty || (lowest_r > in_value)) begin
        lowest_nxt = in_value;
      end
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        pending_r <= 1'b1;
      end else if (load_out) begin
        pending_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    lowest_r <= lowest_nxt;
    if (in_fire) begin
      acc_r <= do_push || do_pop;
    end
    if (load_out) begin
      out_accepted_r <= acc_r;
      out_highest_r  <= empty ? EMPTY_MARK : cval[0];
      out_lowest_r   <= empty ? EMPTY_MARK : lowest_r;
      out_count_r    <= COUNT_OUT_W'(count_r);
      out_empty_r    <= empty;
      out_full_r     <= full;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accepted  = out_accepted_r;
  assign out_highest   = out_highest_r;
  assign out_lowest    = out_lowest_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;
  assign out_full_res  = out_full_r;

  // Count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("count exceeds queue depth");

  // A push on a full queue leaves the count alone.
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_command == CMD_PUSH) && full) |=> (count_r == $past(count_r)))
    else $error("push on full queue changed count");

  // Every accepted request parks a result.
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pending_r)
    else $error("accepted request left no pending result");

  // Tail entry is never larger than head entry.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (lowest_r <= cval[0]))
    else $error("queue ordering broken");

endmodule

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares, shifts left or right.
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  spq_ctl_t                ctl,
  input  logic                    occ,
  input  logic                    left_gt,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  output logic                    gt,
  output logic signed [VAL_W-1:0] val
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Entry stays ahead of the new value only when strictly larger.
  assign gt  = occ && (val_r > ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push) begin
      if (!gt) begin
        val_nxt = left_gt ? ctl.value : left_val;
      end
    end else if (ctl.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
